>>> design/plti_pkg.sv
`timescale 1ns / 1ps

package plti_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int SCAN_SPAN   = 8;

  localparam int DATA_W   = 32;
  localparam int WORD_W   = 2 * DATA_W;
  localparam int SPAN_W   = DATA_W + 1;
  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W  = 10;
  localparam int PCOUNT_W = 11;
  localparam int T_W      = FRAC_BITS + 1;
  localparam int STEP_W   = $clog2(T_W);
  localparam int PROD_W   = SPAN_W + T_W + 1;

  localparam logic [T_W-1:0]    T_ONE      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PROD_W-1:0] ROUND_BIAS = {{(PROD_W - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    KIND_INTERP = 2'd0,
    KIND_LEFT   = 2'd1,
    KIND_RIGHT  = 2'd2,
    KIND_SINGLE = 2'd3
  } clamp_kind_t;

  typedef struct packed {
    logic                     start;
    logic signed [SPAN_W-1:0] dx;
    logic signed [SPAN_W-1:0] span;
  } div_req_t;

endpackage

>>> design/plti_ram.sv
`timescale 1ns / 1ps

module plti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/plti_div.sv
`timescale 1ns / 1ps

module plti_div import plti_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  div_req_t       req,
  output logic           done,
  output logic [T_W-1:0] t
);

  logic [SPAN_W-1:0] abs_dx;
  logic [SPAN_W-1:0] abs_span;
  logic [DATA_W-1:0] mag_dx;
  logic [DATA_W-1:0] mag_span;
  logic              neg;
  logic              dx_zero;
  logic              trivial;
  logic              saturate;

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [SPAN_W-1:0] rem;
  logic [DATA_W-1:0] den;
  logic [T_W-1:0]    quo;
  logic              ge;
  logic [SPAN_W-1:0] rem_sub;
  logic [T_W-1:0]    quo_step;
  logic              last;

  // magnitudes of 33-bit differences of 32-bit words always fit in 32 bits
  assign abs_dx   = req.dx[SPAN_W-1] ? SPAN_W'(-req.dx) : SPAN_W'(req.dx);
  assign abs_span = req.span[SPAN_W-1] ? SPAN_W'(-req.span) : SPAN_W'(req.span);
  assign mag_dx   = abs_dx[DATA_W-1:0];
  assign mag_span = abs_span[DATA_W-1:0];
  assign dx_zero  = (req.dx == '0);
  assign neg      = req.dx[SPAN_W-1] ^ req.span[SPAN_W-1];
  assign trivial  = neg || dx_zero;
  // quotient of at least two units always clips to one
  assign saturate = ({1'b0, mag_dx} >= {mag_span, 1'b0});

  assign ge       = (rem >= {1'b0, den});
  assign rem_sub  = ge ? (rem - {1'b0, den}) : rem;
  assign quo_step = {quo[T_W-2:0], ge};
  assign last     = (cnt == STEP_W'(T_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (trivial || saturate) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= {1'b0, mag_dx};
      den <= mag_span;
      quo <= '0;
      cnt <= '0;
      if (trivial) begin
        t <= '0;
      end else if (saturate) begin
        t <= T_ONE;
      end
    end else if (busy) begin
      rem <= {rem_sub[DATA_W-1:0], 1'b0};
      quo <= quo_step;
      cnt <= cnt + STEP_W'(1);
      if (last) begin
        t <= (quo_step > T_ONE) ? T_ONE : quo_step;
      end
    end
  end

endmodule

>>> design/plti_blend.sv
`timescale 1ns / 1ps

module plti_blend import plti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] y0,
  input  logic signed [SPAN_W-1:0] dy,
  input  logic [T_W-1:0]           t,
  output logic                     done,
  output logic [DATA_W-1:0]        value
);

  logic                     prod_vld;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] scaled;

  // truncate toward zero: bias negative products before the arithmetic shift
  assign biased = prod + (prod[PROD_W-1] ? $signed(ROUND_BIAS) : $signed(PROD_W'(0)));
  assign scaled = biased >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      prod_vld <= start;
      done     <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(dy) * PROD_W'($signed({1'b0, t}));
    end
    if (prod_vld) begin
      value <= y0 + scaled[DATA_W-1:0];
    end
  end

endmodule

>>> design/piecewise_linear_table_interp.sv
`timescale 1ns / 1ps

// Piecewise-linear lookup over a table of up to 1024 signed Q16.16 breakpoints held in one
// single-port-read RAM of {x, y} words. A word with mode 0 writes one breakpoint in the cycle
// it is taken and gives no result; a word with mode 1 evaluates the curve at query_x and gives
// one result. Evaluation runs one item at a time: a binary search, each halving a RAM read and
// then a compare, narrows the window to at most 8 entries, a linear scan reads and compares
// entry by entry, then two more RAM reads, a 17-step restoring divider for the fraction and a
// two-stage multiply-add. Clamped cases and zero-width segments skip the divider and the
// multiply-add. After the result is loaded the block returns to idle for the next word. The
// result sits in an output register, so a new word can be taken while the previous result is
// still waiting. point_count may only be written while the block is idle.
module piecewise_linear_table_interp import plti_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [PCOUNT_W-1:0]        cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [ENTRY_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0]   point_x,
  input  logic signed [DATA_W-1:0]   point_y,
  input  logic signed [DATA_W-1:0]   query_x,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   curve_value,
  output logic [IDX_W-1:0]           segment_index,
  output logic [1:0]                 clamp_kind
);

  typedef enum logic [13:0] {
    ST_IDLE       = 14'b00000000000001,
    ST_SRCH_RD    = 14'b00000000000010,
    ST_SRCH_CMP   = 14'b00000000000100,
    ST_SCAN_RD    = 14'b00000000001000,
    ST_SCAN_CMP   = 14'b00000000010000,
    ST_RESOLVE    = 14'b00000000100000,
    ST_CLAMP_RD   = 14'b00000001000000,
    ST_CLAMP_CAP  = 14'b00000010000000,
    ST_PT_RD0     = 14'b00000100000000,
    ST_PT_RD1     = 14'b00001000000000,
    ST_PT_CAP     = 14'b00010000000000,
    ST_DIV_WAIT   = 14'b00100000000000,
    ST_BLEND_WAIT = 14'b01000000000000,
    ST_FINISH     = 14'b10000000000000
  } state_t;

  state_t state;

  logic [PCOUNT_W-1:0]      point_count;
  logic [CNT_W-1:0]         count_eff;
  logic signed [DATA_W-1:0] query;
  logic [CNT_W-1:0]         n_eff;
  logic [CNT_W-1:0]         lo;
  logic [CNT_W-1:0]         hi;
  logic [CNT_W-1:0]         k;
  logic [CNT_W-1:0]         pos;
  logic [IDX_W-1:0]         sel_addr;
  logic [IDX_W-1:0]         seg;
  clamp_kind_t              kind;
  logic signed [DATA_W-1:0] res;
  logic signed [DATA_W-1:0] x0;
  logic signed [DATA_W-1:0] y0;
  logic signed [SPAN_W-1:0] dy;

  logic                     in_fire;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_y;
  logic [CNT_W-1:0]         mid;
  logic                     x_gt_q;
  logic [CNT_W-1:0]         lo_upd;
  logic [CNT_W-1:0]         hi_upd;
  logic signed [SPAN_W-1:0] span_cur;

  div_req_t                 div_req;
  logic                     div_done;
  logic [T_W-1:0]           div_t;
  logic                     blend_start;
  logic                     blend_done;
  logic [DATA_W-1:0]        blend_value;
  logic                     out_load;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign ram_we    = in_fire && (mode == MODE_WRITE) && (32'(entry_index) < TABLE_DEPTH);
  assign count_eff = (32'(point_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(point_count);

  assign rd_x = ram_rdata[WORD_W-1:DATA_W];
  assign rd_y = ram_rdata[DATA_W-1:0];

  assign mid    = lo + ((hi - lo) >> 1);
  assign x_gt_q = (rd_x > query);
  assign lo_upd = x_gt_q ? lo : mid;
  assign hi_upd = x_gt_q ? mid : hi;

  always_comb begin
    case (state)
      ST_SRCH_RD: ram_raddr = mid[IDX_W-1:0];
      ST_SCAN_RD: ram_raddr = k[IDX_W-1:0];
      ST_PT_RD1:  ram_raddr = sel_addr + IDX_W'(1);
      default:    ram_raddr = sel_addr;
    endcase
  end

  plti_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_index[IDX_W-1:0]),
    .wdata ({point_x, point_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // in the capture state the RAM word is the right-hand breakpoint
  assign span_cur     = SPAN_W'(rd_x) - SPAN_W'(x0);
  assign div_req.start = (state == ST_PT_CAP) && (span_cur != '0);
  assign div_req.dx    = SPAN_W'(query) - SPAN_W'(x0);
  assign div_req.span  = span_cur;

  plti_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .t    (div_t)
  );

  assign blend_start = (state == ST_DIV_WAIT) && div_done;

  plti_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .start (blend_start),
    .y0    (y0),
    .dy    (dy),
    .t     (div_t),
    .done  (blend_done),
    .value (blend_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_write_en) begin
      point_count <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire && (mode == MODE_EVAL)) begin
            query    <= query_x;
            n_eff    <= count_eff;
            lo       <= '0;
            hi       <= count_eff;
            k        <= '0;
            seg      <= '0;
            sel_addr <= '0;
            kind     <= KIND_SINGLE;
            if (count_eff == '0) begin
              res   <= '0;
              state <= ST_FINISH;
            end else if (count_eff == CNT_W'(1)) begin
              state <= ST_CLAMP_RD;
            end else if (count_eff > CNT_W'(SCAN_SPAN)) begin
              state <= ST_SRCH_RD;
            end else begin
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_SRCH_RD: begin
          state <= ST_SRCH_CMP;
        end
        ST_SRCH_CMP: begin
          lo <= lo_upd;
          hi <= hi_upd;
          k  <= lo_upd;
          if ((hi_upd - lo_upd) > CNT_W'(SCAN_SPAN)) begin
            state <= ST_SRCH_RD;
          end else begin
            state <= ST_SCAN_RD;
          end
        end
        ST_SCAN_RD: begin
          if (k == hi) begin
            pos   <= hi;
            state <= ST_RESOLVE;
          end else begin
            state <= ST_SCAN_CMP;
          end
        end
        ST_SCAN_CMP: begin
          if (rd_x >= query) begin
            pos   <= k;
            state <= ST_RESOLVE;
          end else begin
            k     <= k + CNT_W'(1);
            state <= ST_SCAN_RD;
          end
        end
        ST_RESOLVE: begin
          // pos is one past the left breakpoint
          if (pos == '0) begin
            sel_addr <= '0;
            seg      <= '0;
            kind     <= KIND_LEFT;
            state    <= ST_CLAMP_RD;
          end else if (pos >= n_eff) begin
            sel_addr <= IDX_W'(n_eff - CNT_W'(1));
            seg      <= IDX_W'(n_eff - CNT_W'(1));
            kind     <= KIND_RIGHT;
            state    <= ST_CLAMP_RD;
          end else begin
            sel_addr <= IDX_W'(pos - CNT_W'(1));
            seg      <= IDX_W'(pos - CNT_W'(1));
            kind     <= KIND_INTERP;
            state    <= ST_PT_RD0;
          end
        end
        ST_CLAMP_RD: begin
          state <= ST_CLAMP_CAP;
        end
        ST_CLAMP_CAP: begin
          res   <= rd_y;
          state <= ST_FINISH;
        end
        ST_PT_RD0: begin
          state <= ST_PT_RD1;
        end
        ST_PT_RD1: begin
          x0    <= rd_x;
          y0    <= rd_y;
          state <= ST_PT_CAP;
        end
        ST_PT_CAP: begin
          dy <= SPAN_W'(rd_y) - SPAN_W'(y0);
          if (span_cur == '0) begin
            res   <= y0;
            state <= ST_FINISH;
          end else begin
            state <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            state <= ST_BLEND_WAIT;
          end
        end
        ST_BLEND_WAIT: begin
          if (blend_done) begin
            res   <= blend_value;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output word register
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      curve_value   <= res;
      segment_index <= seg;
      clamp_kind    <= kind;
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_blend_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    blend_done |-> (state == ST_BLEND_WAIT))
    else $error("blend finished outside its wait state");

  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_RD) |-> ((k >= lo) && (k <= hi) && (lo < hi)))
    else $error("scan pointer left the search window");

  a_search_narrows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_CMP) |=> ((hi - lo) < $past(hi - lo)))
    else $error("binary search step did not narrow the window");
`endif

endmodule
